### hdl/ehd_pkg.sv
// ----------------------------------------------------------------------------
// ehd_pkg
// Constants, reciprocal divisors and character tables for the date formatter.
// ----------------------------------------------------------------------------
package ehd_pkg;

   localparam int DATE_LEN   = 29;
   localparam int POS_W      = 5;
   localparam logic [POS_W-1:0] LAST_POS = POS_W'(DATE_LEN - 1);

   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 16;
   localparam int EPOCH_W    = 41;

   // calendar constants
   localparam longint SEC_PER_DAY   = 86400;
   localparam longint SEC_PER_HOUR  = 3600;
   localparam longint SEC_PER_MIN   = 60;
   localparam longint DAYS_PER_ERA  = 146097;
   localparam longint DAYS_PER_YEAR = 365;
   localparam longint YEARS_PER_ERA = 400;
   localparam longint DAYS_TO_EPOCH = 719468;   // 0000-03-01 to 1970-01-01
   localparam longint YEAR_MAX      = 9999;

   // day bias keeps the seconds count non-negative; era bias does the same for days
   localparam longint DAY_BIAS   = ((longint'(1) << (EPOCH_W - 1)) + SEC_PER_DAY - 1)
                                   / SEC_PER_DAY;
   localparam longint EPOCH_BIAS = DAY_BIAS * SEC_PER_DAY;
   localparam longint ERA_BIAS   = (DAY_BIAS - DAYS_TO_EPOCH + DAYS_PER_ERA - 1)
                                   / DAYS_PER_ERA;
   localparam longint ERA_OFFSET = ERA_BIAS * DAYS_PER_ERA + DAYS_TO_EPOCH - DAY_BIAS;
   localparam longint WDAY_OFF   = (11 - (DAY_BIAS % 7)) % 7;
   localparam longint YEAR_BIAS  = ERA_BIAS * YEARS_PER_ERA;

   // reciprocals, ceil(2^k / d), k chosen so the quotient is exact over the input range
   localparam logic [18:0] RCP_675_HI = 19'(((longint'(1) << 28) + 674) / 675);
   localparam logic [27:0] RCP_675_LO = 28'(((longint'(1) << 37) + 674) / 675);
   localparam logic [17:0] RCP_HOUR   = 18'(((longint'(1) << 29) + 3599) / 3600);
   localparam logic [26:0] RCP_ERA    = 27'(((longint'(1) << 44) + 146096) / 146097);
   localparam logic [12:0] RCP_MIN    = 13'(((longint'(1) << 18) + 59) / 60);
   localparam logic [18:0] RCP_1460   = 19'(((longint'(1) << 29) + 1459) / 1460);
   localparam logic [18:0] RCP_36524  = 19'(((longint'(1) << 34) + 36523) / 36524);
   localparam logic [18:0] RCP_365    = 19'(((longint'(1) << 27) + 364) / 365);
   localparam logic [9:0]  RCP_C100   = 10'(((longint'(1) << 16) + 99) / 100);
   localparam logic [11:0] RCP_153    = 12'(((longint'(1) << 19) + 152) / 153);
   localparam logic [14:0] RCP_1000   = 15'(((longint'(1) << 24) + 999) / 1000);
   localparam logic [14:0] RCP_Y100   = 15'(((longint'(1) << 21) + 99) / 100);
   localparam logic [14:0] RCP_Y10    = 15'(((longint'(1) << 18) + 9) / 10);
   localparam logic [6:0]  RCP_D10    = 7'(((longint'(1) << 10) + 9) / 10);

   localparam logic [9:0]  DIV_675    = 10'd675;
   localparam logic [17:0] DOE_LAST   = 18'(DAYS_PER_ERA - 1);

   // characters
   localparam logic [7:0] CH_ZERO  = "0";
   localparam logic [7:0] CH_COMMA = ",";
   localparam logic [7:0] CH_SPACE = " ";
   localparam logic [7:0] CH_COLON = ":";
   localparam logic [7:0] CH_G     = "G";
   localparam logic [7:0] CH_M     = "M";
   localparam logic [7:0] CH_T     = "T";

   typedef logic [23:0] name3_type;

   typedef struct packed {
      logic [2:0] wd;
      logic [4:0] hr;
      logic [5:0] mi;
      logic [5:0] se;
   } tod_type;

   typedef struct packed {
      logic [2:0] wd;
      logic [3:0] mon;
      logic [3:0] dom_t;
      logic [3:0] dom_o;
      logic [3:0] yr_3;
      logic [3:0] yr_2;
      logic [3:0] yr_1;
      logic [3:0] yr_0;
      logic [3:0] hr_t;
      logic [3:0] hr_o;
      logic [3:0] mi_t;
      logic [3:0] mi_o;
      logic [3:0] se_t;
      logic [3:0] se_o;
   } date_type;

   function automatic logic [8:0] div675_hi(input logic [17:0] x);
      logic [36:0] p;
      p = 37'(x) * 37'(RCP_675_HI);
      return p[36:28];
   endfunction

   function automatic logic [16:0] div675_lo(input logic [26:0] x);
      logic [54:0] p;
      p = 55'(x) * 55'(RCP_675_LO);
      return p[53:37];
   endfunction

   function automatic logic [4:0] div_hour(input logic [16:0] x);
      logic [34:0] p;
      p = 35'(x) * 35'(RCP_HOUR);
      return p[33:29];
   endfunction

   function automatic logic [8:0] div_era(input logic [25:0] x);
      logic [52:0] p;
      p = 53'(x) * 53'(RCP_ERA);
      return p[52:44];
   endfunction

   function automatic logic [5:0] div_min(input logic [11:0] x);
      logic [24:0] p;
      p = 25'(x) * 25'(RCP_MIN);
      return p[23:18];
   endfunction

   function automatic logic [6:0] div_1460(input logic [17:0] x);
      logic [36:0] p;
      p = 37'(x) * 37'(RCP_1460);
      return p[35:29];
   endfunction

   function automatic logic [2:0] div_36524(input logic [17:0] x);
      logic [36:0] p;
      p = 37'(x) * 37'(RCP_36524);
      return p[36:34];
   endfunction

   function automatic logic [8:0] div_365(input logic [17:0] x);
      logic [36:0] p;
      p = 37'(x) * 37'(RCP_365);
      return p[35:27];
   endfunction

   function automatic logic [1:0] div_c100(input logic [8:0] x);
      logic [18:0] p;
      p = 19'(x) * 19'(RCP_C100);
      return p[17:16];
   endfunction

   function automatic logic [3:0] div_153(input logic [10:0] x);
      logic [22:0] p;
      p = 23'(x) * 23'(RCP_153);
      return p[22:19];
   endfunction

   function automatic logic [3:0] div_1000(input logic [13:0] x);
      logic [28:0] p;
      p = 29'(x) * 29'(RCP_1000);
      return p[27:24];
   endfunction

   function automatic logic [6:0] div_y100(input logic [13:0] x);
      logic [28:0] p;
      p = 29'(x) * 29'(RCP_Y100);
      return p[27:21];
   endfunction

   function automatic logic [9:0] div_y10(input logic [13:0] x);
      logic [28:0] p;
      p = 29'(x) * 29'(RCP_Y10);
      return p[27:18];
   endfunction

   function automatic logic [2:0] div_d10(input logic [5:0] x);
      logic [12:0] p;
      p = 13'(x) * 13'(RCP_D10);
      return p[12:10];
   endfunction

   // 8 is 1 mod 7, so octal digits fold
   function automatic logic [2:0] mod7(input logic [25:0] x);
      logic [26:0] xe;
      logic [5:0]  s;
      logic [3:0]  t;
      xe = {1'b0, x};
      s  = '0;
      for (int i = 0; i < 9; i++) begin
         s = s + 6'(xe[3*i +: 3]);
      end
      t = 4'(s[5:3]) + 4'(s[2:0]);
      if (t >= 4'd7) t = t - 4'd7;
      if (t >= 4'd7) t = t - 4'd7;
      return t[2:0];
   endfunction

   // first day of a March-based month within the year
   function automatic logic [8:0] month_start(input logic [3:0] mp);
      logic [8:0] d;
      case (mp)
         4'd0:    d = 9'd0;
         4'd1:    d = 9'd31;
         4'd2:    d = 9'd61;
         4'd3:    d = 9'd92;
         4'd4:    d = 9'd122;
         4'd5:    d = 9'd153;
         4'd6:    d = 9'd184;
         4'd7:    d = 9'd214;
         4'd8:    d = 9'd245;
         4'd9:    d = 9'd275;
         4'd10:   d = 9'd306;
         4'd11:   d = 9'd337;
         default: d = 9'd0;
      endcase
      return d;
   endfunction

   function automatic name3_type wday_name(input logic [2:0] wd);
      name3_type n;
      case (wd)
         3'd0:    n = "Sun";
         3'd1:    n = "Mon";
         3'd2:    n = "Tue";
         3'd3:    n = "Wed";
         3'd4:    n = "Thu";
         3'd5:    n = "Fri";
         3'd6:    n = "Sat";
         default: n = "Sun";
      endcase
      return n;
   endfunction

   function automatic name3_type mon_name(input logic [3:0] mon);
      name3_type n;
      case (mon)
         4'd1:    n = "Jan";
         4'd2:    n = "Feb";
         4'd3:    n = "Mar";
         4'd4:    n = "Apr";
         4'd5:    n = "May";
         4'd6:    n = "Jun";
         4'd7:    n = "Jul";
         4'd8:    n = "Aug";
         4'd9:    n = "Sep";
         4'd10:   n = "Oct";
         4'd11:   n = "Nov";
         4'd12:   n = "Dec";
         default: n = "Jan";
      endcase
      return n;
   endfunction

   function automatic logic [7:0] dchar(input logic [3:0] d);
      return CH_ZERO | {4'h0, d};
   endfunction

endpackage

### hdl/epoch_to_http_date_text_core.sv
// ----------------------------------------------------------------------------
// epoch_to_http_date_text_core
// Signed Unix seconds to the 29-character HTTP date "Day, DD Mon YYYY HH:MM:SS GMT".
// ----------------------------------------------------------------------------
// Usage:
//   req_ carries one signed 41-bit time per beat. rsp_ returns the 29 characters
//   of its date, one per beat, position 0 first, tlast on the closing 'T'.
//   Years outside 0..9999 print as 9999; all other fields stay true.
//   The first character is valid once the time has passed the calculation
//   pipeline and been loaded into the output line register, which sends
//   one character per beat; the 16-stage calculation pipeline in front of it
//   takes a new time each cycle while it has room, so up to 16 dates queue
//   behind the one being sent.
//   When the receiver stalls, the current character holds and the pipeline
//   freezes as a whole once its last stage is full; req_tready falls then.
//   Reset clears the stage valid bits and the output; no time is lost or repeated
//   across a stall, but items in flight at reset are dropped.
// ----------------------------------------------------------------------------
module epoch_to_http_date_text_core (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [ehd_pkg::REQ_DATA_W-1:0]  req_tdata,   // [40:0] epoch_seconds
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [ehd_pkg::RSP_DATA_W-1:0]  rsp_tdata,   // [7:0] text_byte, [12:8] byte_position
   output logic                            rsp_tlast    // last_byte
);
   import ehd_pkg::*;

   localparam int STAGES = 16;

   logic [STAGES-1:0] vld_ff;
   logic              adv;
   logic              load_in;

   // stage 1: bias to non-negative, split off the factor 128 of 86400
   logic [41:0] u_in;
   logic [34:0] v1_ff;
   logic [6:0]  lo1_ff;
   // stages 2..5: divide by 675 in two halves
   logic [8:0]  qh_in, qh2_ff, qh3_ff, qh4_ff;
   logic [17:0] vh2_ff;
   logic [16:0] vl2_ff, vl3_ff;
   logic [6:0]  lo2_ff, lo3_ff, lo4_ff;
   logic [9:0]  rh_in, rh3_ff;
   logic [26:0] x_in, x4_ff;
   logic [16:0] ql_in, ql4_ff;
   logic [9:0]  rl_in;
   logic [25:0] q5_ff;
   logic [16:0] sod5_ff, sod6_ff;
   // stages 6..9: eras, time of day
   logic [25:0] w_in, w6_ff, w7_ff;
   tod_type     tod_in, tod6_ff, tod7_ff, tod8_ff, tod9_ff, tod10_ff, tod11_ff;
   tod_type     tod12_ff, tod13_ff, tod14_ff, tod15_ff;
   logic [8:0]  era_in, era7_ff, era8_ff, era9_ff, era10_ff, era11_ff, era12_ff;
   logic [11:0] sh_in, sh7_ff, sh8_ff;
   logic [17:0] doe_in, doe8_ff, doe9_ff, doe10_ff, doe11_ff;
   logic [5:0]  mi_in, se_in;
   logic [6:0]  a9_ff;
   logic [2:0]  b9_ff;
   logic        c9_ff;
   // stages 10..14: civil date
   logic [17:0] num_in, num10_ff;
   logic [8:0]  yoe11_ff, yoe12_ff;
   logic [17:0] ysum_in;
   logic [8:0]  doy_in, doy12_ff, doy13_ff;
   logic [10:0] mpx_in;
   logic [3:0]  mp13_ff;
   logic signed [18:0] yb_in, yb13_ff, yr_in;
   logic [3:0]  mon_in, mon14_ff, mon15_ff;
   logic [4:0]  dom_in, dom14_ff, dom15_ff;
   logic [13:0] yclamp_in, yr14_ff, yr15_ff;
   // stages 15..16: decimal digits
   logic [3:0]  y1000_15_ff;
   logic [6:0]  y100_15_ff;
   logic [9:0]  y10_15_ff;
   logic [2:0]  dt15_ff, ht15_ff, mt15_ff, st15_ff;
   date_type    rec_in, rec16_ff;
   // output line register and character position
   logic [7:0]       line_in [DATE_LEN];
   logic [7:0]       line_ff [DATE_LEN];
   logic [POS_W-1:0] pos_ff;
   logic             out_vld_ff;
   logic             rsp_beat;
   logic             at_last;
   name3_type        wname, mname;

   // ---------------- handshake ----------------
   assign rsp_beat   = out_vld_ff & rsp_tready;
   assign at_last    = (pos_ff == LAST_POS);
   assign load_in    = vld_ff[STAGES-1] & (~out_vld_ff | (rsp_beat & at_last));
   assign adv        = ~vld_ff[STAGES-1] | load_in;
   assign req_tready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[STAGES-2:0], req_tvalid};
      end
   end

   // ---------------- datapath ----------------
   always_comb begin
      u_in   = {req_tdata[EPOCH_W-1], req_tdata[EPOCH_W-1:0]} + 42'(EPOCH_BIAS);
      qh_in  = div675_hi(v1_ff[34:17]);
      rh_in  = 10'(vh2_ff - 18'(qh2_ff) * 18'(DIV_675));
      x_in   = {rh3_ff, vl3_ff};
      ql_in  = div675_lo(x_in);
      rl_in  = 10'(x4_ff - 27'(ql4_ff) * 27'(DIV_675));

      w_in      = q5_ff + 26'(ERA_OFFSET);
      tod_in    = '0;
      tod_in.wd = mod7(q5_ff + 26'(WDAY_OFF));
      tod_in.hr = div_hour(sod5_ff);

      era_in = div_era(w6_ff);
      sh_in  = 12'(sod6_ff - 17'(tod6_ff.hr) * 17'(SEC_PER_HOUR));
      doe_in = 18'(w7_ff - 26'(era7_ff) * 26'(DAYS_PER_ERA));
      mi_in  = div_min(sh7_ff);
      se_in  = 6'(sh8_ff - 12'(tod8_ff.mi) * 12'(SEC_PER_MIN));

      num_in  = doe9_ff - 18'(a9_ff) + 18'(b9_ff) - 18'(c9_ff);
      ysum_in = 18'(yoe11_ff) * 18'(DAYS_PER_YEAR) + 18'(yoe11_ff[8:2])
                - 18'(div_c100(yoe11_ff));
      doy_in  = 9'(doe11_ff - ysum_in);
      mpx_in  = {doy12_ff, 2'b00} + 11'(doy12_ff) + 11'd2;
      yb_in   = $signed(19'(yoe12_ff) + 19'(era12_ff) * 19'(YEARS_PER_ERA)
                        - 19'(YEAR_BIAS));

      dom_in = 5'(doy13_ff - month_start(mp13_ff) + 9'd1);
      mon_in = (mp13_ff < 4'd10) ? mp13_ff + 4'd3 : mp13_ff - 4'd9;
      yr_in  = yb13_ff + $signed(19'(mon_in <= 4'd2));
      if (yr_in[18] || (yr_in > $signed(19'(YEAR_MAX)))) begin
         yclamp_in = 14'(YEAR_MAX);
      end else begin
         yclamp_in = yr_in[13:0];
      end

      rec_in.wd    = tod15_ff.wd;
      rec_in.mon   = mon15_ff;
      rec_in.dom_t = 4'(dt15_ff);
      rec_in.dom_o = 4'(dom15_ff - 5'(dt15_ff) * 5'd10);
      rec_in.yr_3  = y1000_15_ff;
      rec_in.yr_2  = 4'(y100_15_ff - 7'(y1000_15_ff) * 7'd10);
      rec_in.yr_1  = 4'(y10_15_ff - 10'(y100_15_ff) * 10'd10);
      rec_in.yr_0  = 4'(yr15_ff - 14'(y10_15_ff) * 14'd10);
      rec_in.hr_t  = 4'(ht15_ff);
      rec_in.hr_o  = 4'(tod15_ff.hr - 5'(ht15_ff) * 5'd10);
      rec_in.mi_t  = 4'(mt15_ff);
      rec_in.mi_o  = 4'(tod15_ff.mi - 6'(mt15_ff) * 6'd10);
      rec_in.se_t  = 4'(st15_ff);
      rec_in.se_o  = 4'(tod15_ff.se - 6'(st15_ff) * 6'd10);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         // 1
         v1_ff  <= u_in[41:7];
         lo1_ff <= u_in[6:0];
         // 2
         qh2_ff <= qh_in;
         vh2_ff <= v1_ff[34:17];
         vl2_ff <= v1_ff[16:0];
         lo2_ff <= lo1_ff;
         // 3
         rh3_ff <= rh_in;
         qh3_ff <= qh2_ff;
         vl3_ff <= vl2_ff;
         lo3_ff <= lo2_ff;
         // 4
         x4_ff  <= x_in;
         ql4_ff <= ql_in;
         qh4_ff <= qh3_ff;
         lo4_ff <= lo3_ff;
         // 5
         q5_ff   <= {qh4_ff, ql4_ff};
         sod5_ff <= {rl_in, lo4_ff};
         // 6
         w6_ff   <= w_in;
         sod6_ff <= sod5_ff;
         tod6_ff <= tod_in;
         // 7
         era7_ff <= era_in;
         w7_ff   <= w6_ff;
         sh7_ff  <= sh_in;
         tod7_ff <= tod6_ff;
         // 8
         doe8_ff    <= doe_in;
         era8_ff    <= era7_ff;
         sh8_ff     <= sh7_ff;
         tod8_ff    <= {tod7_ff.wd, tod7_ff.hr, mi_in, tod7_ff.se};
         // 9
         doe9_ff    <= doe8_ff;
         a9_ff      <= div_1460(doe8_ff);
         b9_ff      <= div_36524(doe8_ff);
         c9_ff      <= (doe8_ff == DOE_LAST);
         era9_ff    <= era8_ff;
         tod9_ff    <= {tod8_ff.wd, tod8_ff.hr, tod8_ff.mi, se_in};
         // 10
         num10_ff <= num_in;
         doe10_ff <= doe9_ff;
         era10_ff <= era9_ff;
         tod10_ff <= tod9_ff;
         // 11
         yoe11_ff <= div_365(num10_ff);
         doe11_ff <= doe10_ff;
         era11_ff <= era10_ff;
         tod11_ff <= tod10_ff;
         // 12
         doy12_ff <= doy_in;
         yoe12_ff <= yoe11_ff;
         era12_ff <= era11_ff;
         tod12_ff <= tod11_ff;
         // 13
         mp13_ff  <= div_153(mpx_in);
         doy13_ff <= doy12_ff;
         yb13_ff  <= yb_in;
         tod13_ff <= tod12_ff;
         // 14
         dom14_ff <= dom_in;
         mon14_ff <= mon_in;
         yr14_ff  <= yclamp_in;
         tod14_ff <= tod13_ff;
         // 15
         y1000_15_ff <= div_1000(yr14_ff);
         y100_15_ff  <= div_y100(yr14_ff);
         y10_15_ff   <= div_y10(yr14_ff);
         yr15_ff     <= yr14_ff;
         dom15_ff    <= dom14_ff;
         mon15_ff    <= mon14_ff;
         dt15_ff     <= div_d10(6'(dom14_ff));
         ht15_ff     <= div_d10(6'(tod14_ff.hr));
         mt15_ff     <= div_d10(tod14_ff.mi);
         st15_ff     <= div_d10(tod14_ff.se);
         tod15_ff    <= tod14_ff;
         // 16
         rec16_ff <= rec_in;
      end
   end

   // ---------------- text assembly ----------------
   assign wname = wday_name(rec16_ff.wd);
   assign mname = mon_name(rec16_ff.mon);

   always_comb begin
      line_in[0]  = wname[23:16];
      line_in[1]  = wname[15:8];
      line_in[2]  = wname[7:0];
      line_in[3]  = CH_COMMA;
      line_in[4]  = CH_SPACE;
      line_in[5]  = dchar(rec16_ff.dom_t);
      line_in[6]  = dchar(rec16_ff.dom_o);
      line_in[7]  = CH_SPACE;
      line_in[8]  = mname[23:16];
      line_in[9]  = mname[15:8];
      line_in[10] = mname[7:0];
      line_in[11] = CH_SPACE;
      line_in[12] = dchar(rec16_ff.yr_3);
      line_in[13] = dchar(rec16_ff.yr_2);
      line_in[14] = dchar(rec16_ff.yr_1);
      line_in[15] = dchar(rec16_ff.yr_0);
      line_in[16] = CH_SPACE;
      line_in[17] = dchar(rec16_ff.hr_t);
      line_in[18] = dchar(rec16_ff.hr_o);
      line_in[19] = CH_COLON;
      line_in[20] = dchar(rec16_ff.mi_t);
      line_in[21] = dchar(rec16_ff.mi_o);
      line_in[22] = CH_COLON;
      line_in[23] = dchar(rec16_ff.se_t);
      line_in[24] = dchar(rec16_ff.se_o);
      line_in[25] = CH_SPACE;
      line_in[26] = CH_G;
      line_in[27] = CH_M;
      line_in[28] = CH_T;
   end

   always_ff @(posedge clock) begin
      if (load_in) begin
         line_ff <= line_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
         pos_ff     <= '0;
      end else if (load_in) begin
         out_vld_ff <= 1'b1;
         pos_ff     <= '0;
      end else if (rsp_beat) begin
         if (at_last) begin
            out_vld_ff <= 1'b0;
         end else begin
            pos_ff <= pos_ff + POS_W'(1);
         end
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {3'b000, pos_ff, line_ff[pos_ff]};
   assign rsp_tlast  = at_last;

endmodule

### bench/tb_epoch_to_http_date_text_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_epoch_to_http_date_text_core
// Self-checking bench for the Unix-seconds to HTTP date text formatter.
// ----------------------------------------------------------------------------
// A table of directed times goes first: epoch edges, negative times, leap day,
// the year 0 and year 9999 limits with the clamp either side, the 41-bit
// extremes and set padding bits. Then random times, mostly inside years
// 0..9999, in four idling phases. Every character beat is compared with the
// oldest expected character, from the table or from the calendar predictor.
// ----------------------------------------------------------------------------
module tb_epoch_to_http_date_text_core;

   localparam int     CYCLE_LIMIT     = 400000;
   localparam int     RANDOM_PER_PHASE = 100;
   localparam longint YEAR0_START     = -62167219200;
   localparam longint YEAR10000_START = 253402300800;
   localparam longint YEAR_SPAN       = 315569520000;
   localparam longint SECS_MAX        = 1099511627775;
   localparam longint SECS_MIN        = -1099511627776;

   typedef struct packed {
      logic [ehd_pkg::RSP_DATA_W-1:0] data;
      logic                           last;
   } date_beat_type;

   typedef struct {
      logic [ehd_pkg::REQ_DATA_W-1:0] word;
      string                          text;
   } date_case_type;

   logic                           clock      = 1'b0;
   logic                           reset      = 1'b1;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic [ehd_pkg::REQ_DATA_W-1:0] req_tdata  = '0;   // [40:0] epoch_seconds
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   logic [ehd_pkg::RSP_DATA_W-1:0] rsp_tdata;         // [7:0] text_byte, [12:8] byte_position
   logic                           rsp_tlast;         // last_byte

   date_beat_type date_chars_due [$];
   int         send_idle_pct = 0;
   int         rsp_stall_pct = 0;
   int         dates_sent    = 0;
   int         chars_checked = 0;
   int         mismatches    = 0;
   int         cycle_count   = 0;

   // empty text: expectation comes from the predictor
   date_case_type directed_cases [20] = '{
      '{{7'h00, 41'sd0},                "Thu, 01 Jan 1970 00:00:00 GMT"},
      '{{7'h00, -41'sd1},               "Wed, 31 Dec 1969 23:59:59 GMT"},
      '{{7'h00, 41'sd86399},            "Thu, 01 Jan 1970 23:59:59 GMT"},
      '{{7'h00, 41'sd86400},            "Fri, 02 Jan 1970 00:00:00 GMT"},
      '{{7'h7F, 41'sd0},                "Thu, 01 Jan 1970 00:00:00 GMT"},
      '{{7'h55, -41'sd1},               "Wed, 31 Dec 1969 23:59:59 GMT"},
      '{{7'h00, 41'sd951782400},        ""},
      '{{7'h00, 41'sd946684799},        ""},
      '{{7'h00, 41'sd2147483647},       "Tue, 19 Jan 2038 03:14:07 GMT"},
      '{{7'h00, -41'sd2147483648},      "Fri, 13 Dec 1901 20:45:52 GMT"},
      '{{7'h00, -41'sd62167219200},     "Sat, 01 Jan 0000 00:00:00 GMT"},
      '{{7'h00, -41'sd62167219201},     "Fri, 31 Dec 9999 23:59:59 GMT"},
      '{{7'h00, 41'sd253402300799},     "Fri, 31 Dec 9999 23:59:59 GMT"},
      '{{7'h00, 41'sd253402300800},     "Sat, 01 Jan 9999 00:00:00 GMT"},
      '{{7'h00, 41'h0FF_FFFF_FFFF},     ""},
      '{{7'h00, 41'h100_0000_0000},     ""},
      '{{7'h7F, 41'h0FF_FFFF_FFFF},     ""},
      '{{7'h00, 41'sd4294967295},       ""},
      '{{7'h00, -41'sd2203891200},      ""},
      '{{7'h00, 41'sd68169600},         ""}
   };

   epoch_to_http_date_text_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always #10 clock = ~clock;

   function automatic void push_text(input string txt);
      for (int k = 0; k < ehd_pkg::DATE_LEN; k++) begin
         date_chars_due.push_back('{data: {3'b000, 5'(k), 8'(txt[k])},
                                    last: (k == ehd_pkg::DATE_LEN - 1)});
      end
   endfunction

   // civil date by floor division, March-based years in 400-year eras
   function automatic void push_http_date(input logic [40:0] secs_word);
      longint secs, day_num, sec_of_day, wday, shifted, era;
      longint day_of_era, year_of_era, year, day_of_year, mar_month, mday, month;
      string  wday_abbrevs;
      string  mon_abbrevs;
      wday_abbrevs = "SunMonTueWedThuFriSat";
      mon_abbrevs  = "JanFebMarAprMayJunJulAugSepOctNovDec";
      secs       = longint'($signed(secs_word));
      day_num    = secs / 86400;
      sec_of_day = secs % 86400;
      if (sec_of_day < 0) begin
         sec_of_day += 86400;
         day_num    -= 1;
      end
      wday = (day_num + 4) % 7;
      if (wday < 0) wday += 7;
      shifted     = day_num + 719468;
      era         = (shifted >= 0 ? shifted : shifted - 146096) / 146097;
      day_of_era  = shifted - era * 146097;
      year_of_era = (day_of_era - day_of_era / 1460 + day_of_era / 36524
                     - day_of_era / 146096) / 365;
      year        = year_of_era + era * 400;
      day_of_year = day_of_era - (365 * year_of_era + year_of_era / 4 - year_of_era / 100);
      mar_month   = (5 * day_of_year + 2) / 153;
      mday        = day_of_year - (153 * mar_month + 2) / 5 + 1;
      month       = mar_month < 10 ? mar_month + 3 : mar_month - 9;
      if (month <= 2) year += 1;
      if (year < 0 || year > 9999) year = 9999;
      push_text($sformatf("%s, %02d %s %04d %02d:%02d:%02d GMT",
                          wday_abbrevs.substr(int'(3 * wday), int'(3 * wday + 2)), mday,
                          mon_abbrevs.substr(int'(3 * (month - 1)), int'(3 * month - 1)),
                          year,
                          sec_of_day / 3600, (sec_of_day / 60) % 60, sec_of_day % 60));
   endfunction

   function automatic logic [ehd_pkg::REQ_DATA_W-1:0] random_time_word();
      logic [63:0] raw;
      longint      secs;
      logic [6:0]  upper;
      raw = {$urandom, $urandom};
      case ($urandom_range(9))
         0, 1:       secs = longint'($signed(raw[40:0]));
         2, 3, 4, 5: secs = YEAR0_START + longint'(raw % 64'(YEAR_SPAN));
         6:          secs = longint'($signed(raw[31:0]));
         7: begin
            case ($urandom_range(3))
               0:       secs = YEAR0_START;
               1:       secs = YEAR10000_START;
               2:       secs = 0;
               default: secs = 951782400;
            endcase
            secs += longint'($urandom_range(200000)) - 100000;
         end
         8: secs = raw[63] ? SECS_MAX - longint'($urandom_range(100000))
                           : SECS_MIN + longint'($urandom_range(100000));
         default: secs = longint'($urandom_range(400000)) - 200000;
      endcase
      upper = ($urandom_range(3) == 0) ? 7'($urandom) : 7'h00;
      return {upper, secs[40:0]};
   endfunction

   task automatic send_date(input logic [ehd_pkg::REQ_DATA_W-1:0] word, input string typed);
      int gap;
      gap = 0;
      while ($urandom_range(99) < send_idle_pct) gap++;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= word;
      do @(posedge clock); while (!req_tready);
      if (typed.len() != 0) push_text(typed);
      else push_http_date(word[40:0]);
      dates_sent++;
   endtask

   task automatic note_mismatch(input string msg);
      if (mismatches < 10) $display("MISMATCH @%0t: %s", $realtime, msg);
      mismatches++;
   endtask

   always @(posedge clock) begin : rsp_side
      date_beat_type due;
      if (reset) rsp_tready <= 1'b0;
      else rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
      if (!reset && rsp_tvalid && rsp_tready) begin
         chars_checked++;
         if (date_chars_due.size() == 0) begin
            note_mismatch($sformatf("beat with nothing pending: data %h last %b",
                                    rsp_tdata, rsp_tlast));
         end else begin
            due = date_chars_due.pop_front();
            if (rsp_tdata !== due.data || rsp_tlast !== due.last)
               note_mismatch($sformatf("expected data %h last %b, got data %h last %b",
                                       due.data, due.last, rsp_tdata, rsp_tlast));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d characters outstanding",
                  cycle_count, date_chars_due.size());
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_cases[i]) send_date(directed_cases[i].word, directed_cases[i].text);

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0:       begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1:       begin send_idle_pct = 84; rsp_stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  rsp_stall_pct = 84; end
            default: begin send_idle_pct = 26; rsp_stall_pct = 26; end
         endcase
         repeat (RANDOM_PER_PHASE) send_date(random_time_word(), "");
      end
      req_tvalid <= 1'b0;

      while (date_chars_due.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);

      $display("%0d times formatted (%0d from the directed table), %0d characters checked",
               dates_sent, $size(directed_cases), chars_checked);
      $display("idling phases: none, sender 84%%, receiver 84%%, both 26%%; %0d mismatches",
               mismatches);
      if (mismatches == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
